/* sv/frustum_box_cull_top_assert.svh */
// Assertion helpers for the frustum box culler checker.
`ifndef FRUSTUM_BOX_CULL_TOP_ASSERT_SVH
`define FRUSTUM_BOX_CULL_TOP_ASSERT_SVH

// Implication check, sampled on i_clk, off while reset is held.
`define FBC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant check, sampled on i_clk, off while reset is held.
`define FBC_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

/* sv/fbc_pkg.sv */
package fbc_pkg;

    localparam int L_NUM_PLANES = 6;
    localparam int L_IDX_W      = 3;
    localparam int L_COORD_W    = 16;
    localparam int L_EXT_W      = L_COORD_W + 1;   // corner sum / span
    localparam int L_PROD_W     = 33;              // normal x sum/span
    localparam int L_ACC_W      = 36;              // D, A and D +/- A
    localparam int L_PLANE_W    = 64;
    localparam int L_W_SHIFT    = 15;              // offset scale, 2 * 2^14
    // edges from request accept to result accept
    localparam int L_LATENCY    = 20;

    typedef enum logic [1:0] {
        CLS_OUTSIDE   = 2'd0,
        CLS_INTERSECT = 2'd1,
        CLS_INSIDE    = 2'd2
    } t_cls;

    typedef struct packed {
        logic signed [L_EXT_W-1:0] sum_x;
        logic signed [L_EXT_W-1:0] sum_y;
        logic signed [L_EXT_W-1:0] sum_z;
        logic signed [L_EXT_W-1:0] span_x;
        logic signed [L_EXT_W-1:0] span_y;
        logic signed [L_EXT_W-1:0] span_z;
    } t_box;

    // what moves from one plane cell to the next
    typedef struct packed {
        logic valid;
        logic outside;
        logic straddle;
        t_box box;
    } t_link;

    // |n| for a Q1.14 normal; -2.0 maps to +2.0
    function automatic logic signed [L_EXT_W-1:0] f_mag(
        input logic signed [L_COORD_W-1:0] v
    );
        logic signed [L_EXT_W-1:0] e;
        e = {v[L_COORD_W-1], v};
        return v[L_COORD_W-1] ? -e : e;
    endfunction

endpackage

/* sv/fbc_cell.sv */
module fbc_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [63:0]   i_plane,
    input  fbc_pkg::t_link i_link,
    output fbc_pkg::t_link o_link
);
    import fbc_pkg::*;

    logic [L_PLANE_W-1:0] r_plane;

    logic signed [L_COORD_W-1:0] nx, ny, nz, w;
    logic signed [L_EXT_W-1:0]   ax, ay, az;

    t_link r_s1, r_s2, r_s3, n_s3;
    logic signed [L_PROD_W-1:0] r_pd_x, r_pd_y, r_pd_z, r_pa_x, r_pa_y, r_pa_z;
    logic signed [L_PROD_W-1:0] n_pd_x, n_pd_y, n_pd_z, n_pa_x, n_pa_y, n_pa_z;
    logic signed [L_ACC_W-1:0]  r_d, r_a, n_d, n_a, tot, dif;

    assign nx = r_plane[15:0];
    assign ny = r_plane[31:16];
    assign nz = r_plane[47:32];
    assign w  = r_plane[63:48];

    assign ax = f_mag(nx);
    assign ay = f_mag(ny);
    assign az = f_mag(nz);

    // stage 1: six independent products
    always_comb begin
        n_pd_x = nx * i_link.box.sum_x;
        n_pd_y = ny * i_link.box.sum_y;
        n_pd_z = nz * i_link.box.sum_z;
        n_pa_x = ax * i_link.box.span_x;
        n_pa_y = ay * i_link.box.span_y;
        n_pa_z = az * i_link.box.span_z;
    end

    // stage 2: doubled center distance and projected extent
    always_comb begin
        n_d = L_ACC_W'(r_pd_x) + L_ACC_W'(r_pd_y) + L_ACC_W'(r_pd_z)
            + (L_ACC_W'(w) <<< L_W_SHIFT);
        n_a = L_ACC_W'(r_pa_x) + L_ACC_W'(r_pa_y) + L_ACC_W'(r_pa_z);
    end

    // stage 3: D < -A is outside, D < A straddles
    always_comb begin
        tot = r_d + r_a;
        dif = r_d - r_a;
        n_s3          = r_s2;
        n_s3.outside  = r_s2.outside  | tot[L_ACC_W-1];
        n_s3.straddle = r_s2.straddle | dif[L_ACC_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane  <= '0;
        end else if (i_we) begin
            r_plane  <= i_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s1 <= i_link;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pd_x <= n_pd_x;
        r_pd_y <= n_pd_y;
        r_pd_z <= n_pd_z;
        r_pa_x <= n_pa_x;
        r_pa_y <= n_pa_y;
        r_pa_z <= n_pa_z;
        r_d    <= n_d;
        r_a    <= n_a;
    end

    assign o_link = r_s3;

endmodule

/* sv/frustum_box_cull_top.sv */
// Six-plane frustum cull of axis-aligned boxes.
//
// Request channel: drive the box corners on i_box_min_* / i_box_max_* and
// raise i_start; a request is taken at every edge with i_start high and
// o_busy low. o_busy stays low, so a new box may enter on every cycle.
// Result channel: o_valid strobes for one cycle with o_cull_class
// (0 outside, 1 intersecting, 2 inside). Results come back in request order,
// one per request, after the prep register, three stages per plane cell
// and the output register.
// Throughput is one box per cycle; the plane cells are fully pipelined.
// There is no back-pressure: the receiver must take each strobe.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index (0..5) and
// 64-bit i_cfg_data {w, nz, ny, nx}; indexes 6 and 7 are dropped. Write
// planes only while no request is in flight.
// Reset (i_rst_n low, synchronous) empties the pipe and zeroes all planes,
// which makes every box classify as inside.
module frustum_box_cull_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_box_min_x,
    input  logic [15:0] i_box_min_y,
    input  logic [15:0] i_box_min_z,
    input  logic [15:0] i_box_max_x,
    input  logic [15:0] i_box_max_y,
    input  logic [15:0] i_box_max_z,
    // result
    output logic        o_valid,
    output logic [1:0]  o_cull_class,
    // plane config
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import fbc_pkg::*;

    t_link r_prep, n_prep;
    t_link w_link [0:L_NUM_PLANES];
    logic  r_valid;
    t_cls  r_cls, n_cls;
    logic  [L_NUM_PLANES-1:0] cfg_we;

    // Every cycle can take a request and a config write.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Prep: doubled center and doubled half extent per axis.
    // Inverted boxes are not reordered; span simply goes negative.
    always_comb begin
        n_prep.valid       = i_start && !o_busy;
        n_prep.outside     = 1'b0;
        n_prep.straddle    = 1'b0;
        n_prep.box.sum_x   = L_EXT_W'($signed(i_box_max_x)) + L_EXT_W'($signed(i_box_min_x));
        n_prep.box.sum_y   = L_EXT_W'($signed(i_box_max_y)) + L_EXT_W'($signed(i_box_min_y));
        n_prep.box.sum_z   = L_EXT_W'($signed(i_box_max_z)) + L_EXT_W'($signed(i_box_min_z));
        n_prep.box.span_x  = L_EXT_W'($signed(i_box_max_x)) - L_EXT_W'($signed(i_box_min_x));
        n_prep.box.span_y  = L_EXT_W'($signed(i_box_max_y)) - L_EXT_W'($signed(i_box_min_y));
        n_prep.box.span_z  = L_EXT_W'($signed(i_box_max_z)) - L_EXT_W'($signed(i_box_min_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else begin
            r_prep <= n_prep;
        end
    end

    assign w_link[0] = r_prep;

    // One cell per plane; each cell owns its plane register and
    // ORs its outside / straddle verdict into the passing box.
    for (genvar g = 0; g < L_NUM_PLANES; g++) begin : g_cell
        assign cfg_we[g] = i_cfg_valid && o_cfg_ready && (i_cfg_index == L_IDX_W'(g));

        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (cfg_we[g]),
            .i_plane (i_cfg_data),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // Any outside plane wins; otherwise any straddle means intersecting.
    always_comb begin
        if (w_link[L_NUM_PLANES].outside) begin
            n_cls = CLS_OUTSIDE;
        end else if (w_link[L_NUM_PLANES].straddle) begin
            n_cls = CLS_INTERSECT;
        end else begin
            n_cls = CLS_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_link[L_NUM_PLANES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls <= n_cls;
    end

    assign o_valid      = r_valid;
    assign o_cull_class = r_cls;

endmodule

/* sv/fbc_checker.sv */
`include "frustum_box_cull_top_assert.svh"

module fbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic o_cfg_ready
);
    import fbc_pkg::*;

    // every request gets its strobe after the fixed pipe depth
    `FBC_CHECK(a_req_gets_result, i_start && !o_busy, ##L_LATENCY o_valid, "request lost")
    // no strobe without a request that fixed depth earlier
    `FBC_CHECK(a_no_orphan, o_valid, $past(i_start && !o_busy, L_LATENCY), "stray result")
    // both channels always open
    `FBC_ALWAYS(a_always_open, o_cfg_ready && !o_busy, "channel closed")

endmodule

bind frustum_box_cull_top fbc_checker u_fbc_checker (.*);

/* verif/tb_frustum_box_cull_top.sv */
// Checks the six-plane box culler: planes are loaded through the config
// channel while the pipe is empty. Boxes are then streamed in bursts, and
// every class that comes back is compared, in order, against a local
// fixed-point classifier.
module tb_frustum_box_cull_top;
    import fbc_pkg::*;

    // config register indexes: planes are 0..5, the two codes above are
    // not decoded and must leave the planes alone
    localparam logic [2:0] IDX_PLANE_FIRST = 3'd0;
    localparam logic [2:0] IDX_SPARE_LO    = 3'd6;
    localparam logic [2:0] IDX_SPARE_HI    = 3'd7;

    // Q1.14 constants used by the hand-built frustums
    localparam logic [15:0] Q_ONE     = 16'h4000;   // +1.0
    localparam logic [15:0] Q_NEG_ONE = 16'hC000;   // -1.0
    localparam logic [15:0] Q_NEG_TWO = 16'h8000;   // -2.0, magnitude 2.0

    localparam int PHASES         = 10;
    localparam int BOXES_PER_PHASE = 65;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] min_z;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic signed [15:0] max_z;
    } box_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [15:0] i_box_min_x;
    logic [15:0] i_box_min_y;
    logic [15:0] i_box_min_z;
    logic [15:0] i_box_max_x;
    logic [15:0] i_box_max_y;
    logic [15:0] i_box_max_z;
    logic        o_valid;
    logic [1:0]  o_cull_class;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // local copy of the plane registers, updated on each accepted write
    logic [63:0] plane_cfg [L_NUM_PLANES];
    // classes still owed by the block, oldest first
    t_cls        pending_class [$];

    int err_count;
    int result_count;
    // sender pacing: requests left in the current burst, gaps on or off
    int burst_left;
    bit gaps_on;

    frustum_box_cull_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_box_min_x (i_box_min_x),
        .i_box_min_y (i_box_min_y),
        .i_box_min_z (i_box_min_z),
        .i_box_max_x (i_box_max_x),
        .i_box_max_y (i_box_max_y),
        .i_box_max_z (i_box_max_z),
        .o_valid     (o_valid),
        .o_cull_class(o_cull_class),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Classifier. Everything is doubled and scaled by 2^14 so the
    // comparisons are exact integers:
    //   center_d = sum n*(max+min) + w*2^15
    //   reach    = sum |n|*(max-min)
    // center_d < -reach on any plane -> outside; else center_d < reach on
    // any plane -> intersecting; else inside. Inverted boxes just give a
    // negative reach, nothing is reordered.
    // ---------------------------------------------------------------
    function automatic t_cls cull_class_of(input box_t b);
        longint ctr2 [3];
        longint ext2 [3];
        longint nrm [3];
        longint center_d;
        longint reach;
        bit     straddle;
        straddle = 1'b0;
        ctr2[0] = longint'($signed(b.max_x)) + longint'($signed(b.min_x));
        ctr2[1] = longint'($signed(b.max_y)) + longint'($signed(b.min_y));
        ctr2[2] = longint'($signed(b.max_z)) + longint'($signed(b.min_z));
        ext2[0] = longint'($signed(b.max_x)) - longint'($signed(b.min_x));
        ext2[1] = longint'($signed(b.max_y)) - longint'($signed(b.min_y));
        ext2[2] = longint'($signed(b.max_z)) - longint'($signed(b.min_z));
        for (int p = 0; p < L_NUM_PLANES; p++) begin
            nrm[0]   = longint'($signed(plane_cfg[p][15:0]));
            nrm[1]   = longint'($signed(plane_cfg[p][31:16]));
            nrm[2]   = longint'($signed(plane_cfg[p][47:32]));
            center_d = longint'($signed(plane_cfg[p][63:48])) * 32768;
            reach    = 0;
            for (int a = 0; a < 3; a++) begin
                center_d += nrm[a] * ctr2[a];
                reach    += ((nrm[a] < 0) ? -nrm[a] : nrm[a]) * ext2[a];
            end
            if (center_d < -reach)
                return CLS_OUTSIDE;
            if (center_d < reach)
                straddle = 1'b1;
        end
        return straddle ? CLS_INTERSECT : CLS_INSIDE;
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic box_t make_box(input int lx, input int ly, input int lz,
                                      input int hx, input int hy, input int hz);
        box_t b;
        b.min_x = sat16(lx);
        b.min_y = sat16(ly);
        b.min_z = sat16(lz);
        b.max_x = sat16(hx);
        b.max_y = sat16(hy);
        b.max_z = sat16(hz);
        return b;
    endfunction

    // {w, nz, ny, nx}
    function automatic logic [63:0] pack_plane(input logic [15:0] nx, input logic [15:0] ny,
                                               input logic [15:0] nz, input logic [15:0] w);
        return {w, nz, ny, nx};
    endfunction

    // mirror a Q1.14 normal; -2.0 has no positive twin, so it clamps
    function automatic logic [15:0] flip_q(input logic [15:0] v);
        return (v == Q_NEG_TWO) ? 16'h7FFF : 16'(-$signed(v));
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // Result checker. The receiver cannot push back, so every strobe is
    // taken and matched against the oldest owed class.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_class.size() == 0) begin
                report_mismatch($sformatf("unexpected result, cull_class %0d", o_cull_class));
            end else begin
                t_cls want;
                want = pending_class.pop_front();
                if (o_cull_class !== want)
                    report_mismatch($sformatf("result %0d cull_class got %0d want %0d",
                                              result_count, o_cull_class, want));
            end
            result_count++;
        end
    end

    // ---------------------------------------------------------------
    // Request side. Called at a rising edge; start stays high between
    // back-to-back requests and only drops when a gap is taken.
    // ---------------------------------------------------------------
    task automatic send_box(input box_t b);
        if (gaps_on && burst_left == 0) begin
            i_start <= 1'b0;
            // mostly short gaps, now and then a longer one that can outlast the pipe
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 6))
                @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        i_start     <= 1'b1;
        i_box_min_x <= b.min_x;
        i_box_min_y <= b.min_y;
        i_box_min_z <= b.min_z;
        i_box_max_x <= b.max_x;
        i_box_max_y <= b.max_y;
        i_box_max_z <= b.max_z;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        pending_class.push_back(cull_class_of(b));
    endtask

    // Drops start and waits for every owed class; a missing one is a
    // failure, not a hang.
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        while (pending_class.size() != 0 && waited < 4 * L_LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_class.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_class.size()));
            pending_class.delete();
        end
        repeat (2) @(posedge i_clk);
    endtask

    // One config write; valid stays up so writes can go back to back.
    // Indexes past the last plane are sent too and must be dropped.
    task automatic write_plane(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx < L_NUM_PLANES)
            plane_cfg[idx] = data;
    endtask

    task automatic load_planes(input logic [63:0] planes [L_NUM_PLANES]);
        for (int p = 0; p < L_NUM_PLANES; p++)
            write_plane(IDX_PLANE_FIRST + 3'(p), planes[p]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Axis cube |x|,|y|,|z| <= half, built from unit normals.
    task automatic load_cube(input int half);
        logic [63:0] planes [L_NUM_PLANES];
        planes[0] = pack_plane(Q_ONE,     16'h0,     16'h0,     16'(half));
        planes[1] = pack_plane(Q_NEG_ONE, 16'h0,     16'h0,     16'(half));
        planes[2] = pack_plane(16'h0,     Q_ONE,     16'h0,     16'(half));
        planes[3] = pack_plane(16'h0,     Q_NEG_ONE, 16'h0,     16'(half));
        planes[4] = pack_plane(16'h0,     16'h0,     Q_ONE,     16'(half));
        planes[5] = pack_plane(16'h0,     16'h0,     Q_NEG_ONE, 16'(half));
        load_planes(planes);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Zeroed planes after reset: every box, even inverted, is inside.
    task automatic test_reset_planes();
        gaps_on = 1'b0;
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
        wait_drained();
    endtask

    // Hand-built cube, then the -2.0 normal, spare indexes and zero planes.
    task automatic test_directed_planes();
        gaps_on = 1'b0;
        load_cube(1000);
        send_box(make_box(-10, -10, -10, 10, 10, 10));              // inside
        send_box(make_box(-1100, -10, -10, -900, 10, 10));          // straddles -x
        send_box(make_box(2000, 0, 0, 3000, 10, 10));               // outside
        send_box(make_box(1000, 0, 0, 1000, 0, 0));                 // point on a plane
        send_box(make_box(1001, 0, 0, 1001, 0, 0));                 // point just past
        send_box(make_box(0, 0, 0, 1000, 1000, 1000));              // face touching
        send_box(make_box(500, 500, 500, -500, -500, -500));        // inverted
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(5000, 0, 0, -5000, 0, 0));                // inverted, wide
        wait_drained();

        // plane 0: -2x + 2000 >= 0, i.e. x <= 1000 with a -2.0 normal
        write_plane(IDX_PLANE_FIRST, pack_plane(Q_NEG_TWO, 16'h0, 16'h0, 16'd2000));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_box(make_box(999, 0, 0, 1001, 0, 0));
        send_box(make_box(1001, 0, 0, 1002, 0, 0));
        send_box(make_box(-999, -999, -999, 999, 999, 999));
        wait_drained();

        // undecoded indexes carry data that would cull everything
        write_plane(IDX_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_plane(IDX_SPARE_HI, 64'h8000_8000_8000_8000);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_box(make_box(-10, -10, -10, 10, 10, 10));
        wait_drained();

        // zero normal, negative offset: everything outside
        write_plane(IDX_PLANE_FIRST + 3'd5, pack_plane(16'h0, 16'h0, 16'h0, 16'hFFFF));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_box(make_box(-10, -10, -10, 10, 10, 10));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        wait_drained();

        // zero normal, zero offset: plane has no say
        write_plane(IDX_PLANE_FIRST + 3'd5, 64'h0);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_box(make_box(-10, -10, -10, 10, 10, 10));
        send_box(make_box(-1100, -10, -10, -900, 10, 10));
        wait_drained();
    endtask

    // Random plane sets and random boxes. Most phases use a closed
    // frustum around the origin so all three classes show up; boxes are
    // sized on a log scale so they land inside, across and beyond it.
    task automatic test_random_stream();
        logic [63:0] planes [L_NUM_PLANES];
        logic [15:0] n [3];
        int          scale;
        int          cx, cy, cz, hx, hy, hz;
        box_t        b;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: for (int p = 0; p < L_NUM_PLANES; p++)
                       planes[p] = 64'h8000_8000_8000_8000;
                1: for (int p = 0; p < L_NUM_PLANES; p++)
                       planes[p] = 64'h7FFF_7FFF_7FFF_7FFF;
                2: for (int p = 0; p < L_NUM_PLANES; p++)
                       planes[p] = {$urandom, $urandom};
                default: begin
                    // opposed plane pairs; origin always on the inner side
                    for (int k = 0; k < 3; k++) begin
                        for (int a = 0; a < 3; a++)
                            n[a] = (a == k) ? 16'($urandom)
                                            : 16'($urandom_range(0, 8191) - 4096);
                        planes[2*k]   = pack_plane(n[0], n[1], n[2],
                                                   16'($urandom_range(0, 32767)));
                        planes[2*k+1] = pack_plane(flip_q(n[0]), flip_q(n[1]),
                                                   flip_q(n[2]),
                                                   16'($urandom_range(0, 32767)));
                    end
                end
            endcase
            load_planes(planes);
            // a stray write to an undecoded index between phases
            if (ph % 2 == 1) begin
                write_plane((ph % 4 == 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                            {$urandom, $urandom});
                i_cfg_valid <= 1'b0;
                @(posedge i_clk);
            end

            // every third phase streams without gaps
            gaps_on    = (ph % 3 != 0);
            burst_left = 0;
            for (int i = 0; i < BOXES_PER_PHASE; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // raw fields, inverted axes included
                        b = {$urandom, $urandom, $urandom};
                    end
                    2: begin
                        cx = $urandom_range(0, 65535) - 32768;
                        cy = $urandom_range(0, 65535) - 32768;
                        cz = $urandom_range(0, 65535) - 32768;
                        b  = make_box(cx, cy, cz, cx, cy, cz);
                    end
                    default: begin
                        scale = 1 << $urandom_range(2, 15);
                        cx = $urandom_range(0, 2 * scale) - scale;
                        cy = $urandom_range(0, 2 * scale) - scale;
                        cz = $urandom_range(0, 2 * scale) - scale;
                        hx = $urandom_range(0, scale);
                        hy = $urandom_range(0, scale);
                        hz = $urandom_range(0, scale);
                        b  = make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
                    end
                endcase
                send_box(b);
            end
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        err_count    = 0;
        result_count = 0;
        burst_left   = 0;
        gaps_on      = 1'b0;
        for (int p = 0; p < L_NUM_PLANES; p++)
            plane_cfg[p] = 64'h0;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_box_min_x <= 16'h0;
        i_box_min_y <= 16'h0;
        i_box_min_z <= 16'h0;
        i_box_max_x <= 16'h0;
        i_box_max_y <= 16'h0;
        i_box_max_z <= 16'h0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= IDX_PLANE_FIRST;
        i_cfg_data  <= 64'h0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_planes();
        test_directed_planes();
        test_random_stream();

        // catch any late or extra strobe
        repeat (L_LATENCY + 5) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit, far above a worst-case paced run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
